// File: rtl/crcfc_pkg.sv
// shared types, frame constants and the crc byte update for the crc16 frame checker
package crcfc_pkg;

  localparam int PAYLOAD_BYTES = 18;
  localparam int FRAME_BYTES   = 20;
  localparam int PosW          = $clog2(FRAME_BYTES);

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [7:0]  CMD_STATUS  = 8'h03;
  localparam logic [7:0]  CMD_START   = 8'h05;
  localparam logic [7:0]  STATUS_DONE = 8'h02;
  localparam logic [7:0]  RESULT_OK   = 8'h00;

  localparam logic [PosW-1:0] POS_CMD     = PosW'(1);
  localparam logic [PosW-1:0] POS_STATUS  = PosW'(2);
  localparam logic [PosW-1:0] POS_RESULT  = PosW'(4);
  localparam logic [PosW-1:0] POS_TRAILER = PosW'(PAYLOAD_BYTES);
  localparam logic [PosW-1:0] POS_LAST    = PosW'(FRAME_BYTES - 1);

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } item_t;

  typedef struct packed {
    logic        crc_good;
    logic [7:0]  command;
    logic        motor_done_ok;
    logic        start_acknowledged;
    logic [15:0] computed_crc;
  } result_t;

  // reflected crc-16, eight bit steps unrolled
  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in,
                                                input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/crcfc_frame_track.sv
// frame position, running crc, kept header bytes and the end-of-frame verdict
module crcfc_frame_track (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  crcfc_pkg::item_t  beat,
  output logic              has_result,
  output crcfc_pkg::result_t verdict
);

  logic [crcfc_pkg::PosW-1:0] byte_position;
  logic [crcfc_pkg::PosW-1:0] byte_position_next;
  logic [15:0]                crc_register;
  logic [15:0]                crc_register_next;
  logic [7:0]                 command_hold;
  logic [7:0]                 command_hold_next;
  logic [7:0]                 status_hold;
  logic [7:0]                 status_hold_next;
  logic [7:0]                 result_hold;
  logic [7:0]                 result_hold_next;
  logic [7:0]                 trailer_low;
  logic [7:0]                 trailer_low_next;

  logic [crcfc_pkg::PosW-1:0] pos;
  logic [15:0]                crc_base;
  logic [15:0]                crc_upd;
  logic                       good;

  always_comb begin
    pos      = beat.frame_start ? '0 : byte_position;
    crc_base = beat.frame_start ? crcfc_pkg::CRC_INIT : crc_register;

    crc_upd = (pos < crcfc_pkg::POS_TRAILER) ?
              crcfc_pkg::crc_add_byte(crc_base, beat.rx_byte) : crc_base;
    command_hold_next = (pos == crcfc_pkg::POS_CMD)     ? beat.rx_byte : command_hold;
    status_hold_next  = (pos == crcfc_pkg::POS_STATUS)  ? beat.rx_byte : status_hold;
    result_hold_next  = (pos == crcfc_pkg::POS_RESULT)  ? beat.rx_byte : result_hold;
    trailer_low_next  = (pos == crcfc_pkg::POS_TRAILER) ? beat.rx_byte : trailer_low;

    has_result = (pos >= crcfc_pkg::POS_LAST);
    good       = (crc_upd == {beat.rx_byte, trailer_low_next});

    verdict.crc_good           = good;
    verdict.command            = command_hold_next;
    verdict.motor_done_ok      = good && (command_hold_next == crcfc_pkg::CMD_STATUS) &&
                                 (status_hold_next == crcfc_pkg::STATUS_DONE) &&
                                 (result_hold_next == crcfc_pkg::RESULT_OK);
    verdict.start_acknowledged = good && (command_hold_next == crcfc_pkg::CMD_START);
    verdict.computed_crc       = crc_upd;

    // frame end rewinds to a fresh frame
    if (has_result) begin
      byte_position_next = '0;
      crc_register_next  = crcfc_pkg::CRC_INIT;
    end else begin
      byte_position_next = pos + 1'b1;
      crc_register_next  = crc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      crc_register  <= crcfc_pkg::CRC_INIT;
      command_hold  <= '0;
      status_hold   <= '0;
      result_hold   <= '0;
      trailer_low   <= '0;
    end else if (step) begin
      byte_position <= byte_position_next;
      crc_register  <= crc_register_next;
      command_hold  <= command_hold_next;
      status_hold   <= status_hold_next;
      result_hold   <= result_hold_next;
      trailer_low   <= trailer_low_next;
    end
  end

endmodule

// File: rtl/crc16_frame_checker.sv
// top level of the crc16 reply frame checker with input register and result queue
// Checks fixed 20-byte reply frames fed one byte per beat on the item channel. A reflected
// crc-16 (start 0xffff, polynomial 0xa001) runs over bytes 0..17, bytes 18 and 19 are the
// trailer crc (low byte first), and on the last byte one beat leaves on the result channel
// with the crc verdict, the command byte (byte 1), a motor-done flag (command 0x03, status
// byte 2 = 0x02, result byte 4 = 0x00) and a start-ack flag (command 0x05). A beat with
// frame_start high restarts the frame at byte 0; after reset and after each frame the next
// byte is byte 0 even without the mark. Throughput is one byte per clock unless item_stall
// is high: each byte goes from the input register through the unrolled eight-step crc
// update into the state and, on a frame's last byte, into the result register.
// A two-entry result queue (output register plus skid entry) keeps bytes flowing while a
// result waits; item_stall rises only when a frame-ending byte finds both entries full.
module crc16_frame_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  crcfc_pkg::item_t    item,
  output logic                result_valid,
  input  logic                result_stall,
  output crcfc_pkg::result_t  result
);

  // input register
  logic                ib_valid;
  crcfc_pkg::item_t    ib;

  // skid entry behind the result register
  logic                sk_valid;
  crcfc_pkg::result_t  sk;

  logic                has_result;
  crcfc_pkg::result_t  verdict;
  logic                adv;
  logic                push;
  logic                out_take;

  // a byte that makes no result always moves; one that does needs the skid entry free
  assign adv        = ib_valid && (!has_result || !sk_valid);
  assign push       = adv && has_result;
  assign item_stall = ib_valid && !adv;
  assign out_take   = result_valid && !result_stall;

  crcfc_frame_track u_track (
    .clk        (clk),
    .rst        (rst),
    .step       (adv),
    .beat       (ib),
    .has_result (has_result),
    .verdict    (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ib_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      ib_valid <= 1'b1;
      ib       <= item;
    end else if (adv) begin
      ib_valid <= 1'b0;
    end
  end

  // result queue: output register first, skid entry second
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      sk_valid     <= 1'b0;
    end else if (out_take) begin
      if (sk_valid) begin
        result   <= sk;
        sk_valid <= push;
        if (push) begin
          sk <= verdict;
        end
      end else begin
        result_valid <= push;
        if (push) begin
          result <= verdict;
        end
      end
    end else if (!result_valid) begin
      result_valid <= push;
      if (push) begin
        result <= verdict;
      end
    end else if (push) begin
      sk_valid <= 1'b1;
      sk       <= verdict;
    end
  end

`ifndef SYNTHESIS
  // skid entry only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    sk_valid |-> result_valid)
    else $error("skid entry valid with empty result register");

  // a result is never pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !sk_valid)
    else $error("result pushed while queue full");

  // a taken result with a skid entry behind it is followed by that entry
  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    (out_take && sk_valid) |=> result_valid)
    else $error("skid entry lost after result beat");

  // the input stalls only while a frame end waits on a full queue
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (ib_valid && has_result && sk_valid))
    else $error("input stalled without a full result queue");
`endif

endmodule
